/* hdl/rwmf_pkg.sv */
// ----------------------------------------------------------------------------
// rwmf_pkg
// shared constants and types of the rgb window median filter
// ----------------------------------------------------------------------------
`default_nettype none

package rwmf_pkg;

    localparam int MAX_RADIUS_DEF = 5;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int CHAN_W     = 8;
    localparam int RADIUS_W   = 3;
    localparam int DIM_CFG_W  = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int NUM_CHAN   = 3;

    // register indexes of the config port
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

    // item codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CTR_RD,
        ST_CTR_WAIT,
        ST_SCAN,
        ST_TAIL,
        ST_DECIDE,
        ST_OUT
    } rwmf_state_t;

endpackage

`default_nettype wire

/* hdl/rwmf_in_if.sv */
// ----------------------------------------------------------------------------
// rwmf_in_if
// input channel: valid/ready handshake with pixel or drain word
// ----------------------------------------------------------------------------
`default_nettype none

interface rwmf_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;

    modport source (output valid, output op, output red_in, output green_in,
                    output blue_in, output alpha_in, input ready);
    modport sink   (input valid, input op, input red_in, input green_in,
                    input blue_in, input alpha_in, output ready);
endinterface

`default_nettype wire

/* hdl/rwmf_out_if.sv */
// ----------------------------------------------------------------------------
// rwmf_out_if
// output channel: valid/ready handshake with filtered pixel word
// ----------------------------------------------------------------------------
`default_nettype none

interface rwmf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       last_of_frame;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output alpha_out, output last_of_frame, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input alpha_out, input last_of_frame, output ready);
endinterface

`default_nettype wire

/* hdl/rgb_window_median_filter.sv */
// ----------------------------------------------------------------------------
// rgb_window_median_filter
// square window per-channel median filter over a raster stream of argb pixels
// ----------------------------------------------------------------------------
// sequence: pixel words that yield no output stay in ST_IDLE; border outputs pass
//   ST_CTR_RD, ST_CTR_WAIT, ST_OUT; interior ones scan each bit plane first
// throughput: one word at a time, set by the single line store read port that
//   the bit plane counter shares over all window words, once per bit plane
// reset: counters, frame state, config and state registers return to defaults at once;
//   the line store is not cleared, it is only read where written
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_window_median_filter #(
    parameter int MAX_RADIUS = rwmf_pkg::MAX_RADIUS_DEF,
    parameter int MAX_WIDTH  = rwmf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rwmf_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    rwmf_in_if.sink                            pix_in,
    rwmf_out_if.source                         pix_out,
    input  wire logic                          cfg_we,
    input  wire logic [rwmf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rwmf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rwmf_pkg::*;

    // ring of line buffers and derived widths
    localparam int RING  = 2 * MAX_RADIUS + 1;
    localparam int DEPTH = RING * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = (RING > 1) ? $clog2(RING) : 1;
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int WXW   = (WW > DIM_CFG_W) ? WW : DIM_CFG_W;
    localparam int HXW   = (HW > DIM_CFG_W) ? HW : DIM_CFG_W;
    localparam int PW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int DW    = $clog2(2 * MAX_RADIUS + 1);
    localparam int NMAX  = RING * RING;
    localparam int NW    = $clog2(NMAX + 1);
    localparam int WORD_W = 4 * CHAN_W;

    // config registers
    logic [RADIUS_W-1:0]  radius_reg;
    logic [DIM_CFG_W-1:0] frame_width_reg;
    logic [DIM_CFG_W-1:0] frame_height_reg;

    // frame position
    logic [XW-1:0] in_col_reg;
    logic [YW-1:0] in_row_reg;
    logic [SW-1:0] in_slot_reg;
    logic [PW-1:0] in_idx_reg;
    logic          frame_done_reg;
    logic [XW-1:0] out_col_reg;
    logic [YW-1:0] out_row_reg;
    logic [SW-1:0] out_slot_reg;

    // window scan
    logic [DW-1:0] dx_reg;
    logic [DW-1:0] dy_reg;
    logic [XW-1:0] scan_col_reg;
    logic [SW-1:0] scan_slot_reg;
    logic          scan_vld_reg;
    logic [2:0]    bit_reg;
    logic [CHAN_W-1:0] prefix_reg [NUM_CHAN];
    logic [NW-1:0]     rank_reg   [NUM_CHAN];
    logic [NW-1:0]     cnt_reg    [NUM_CHAN];

    // result holding
    logic [CHAN_W-1:0] red_reg, green_reg, blue_reg, alpha_reg;
    logic              last_reg;

    rwmf_state_t state_reg, state_next;

    // line store
    logic [WORD_W-1:0] line_mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic              mem_we;

    // effective config
    logic [RW-1:0]  r_eff;
    logic [WW-1:0]  w_eff;
    logic [HW-1:0]  h_eff;
    logic [WXW-1:0] fw_x;
    logic [HXW-1:0] fh_x;
    logic [PW-1:0]  lag;
    logic [DW-1:0]  span;
    logic [NW-1:0]  win_size;
    logic [SW-1:0]  win_slot0;
    logic [XW-1:0]  win_col0;
    logic           interior;
    logic           out_last;
    logic [7:0]     hi_mask;

    logic in_acc, out_acc, pix_acc, drain_acc, cfg_hit;
    logic [WW-1:0] in_col_inc;
    logic [HW-1:0] in_row_inc;
    logic [WW-1:0] out_col_inc;

    logic [CHAN_W-1:0] prefix_next [NUM_CHAN];
    logic [NW-1:0]     rank_next   [NUM_CHAN];
    logic [NUM_CHAN-1:0] hit;

    always_comb
    begin
        r_eff = (radius_reg > RADIUS_W'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius_reg);
        fw_x  = WXW'(frame_width_reg);
        fh_x  = HXW'(frame_height_reg);
        if (frame_width_reg == '0)
            w_eff = WW'(1);
        else if (fw_x > WXW'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(fw_x);
        if (frame_height_reg == '0)
            h_eff = HW'(1);
        else if (fh_x > HXW'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(fh_x);
    end

    assign lag      = PW'(PW'(r_eff) * PW'(w_eff)) + PW'(r_eff);
    assign span     = DW'({r_eff, 1'b0});
    assign win_size = NW'(NW'(span + DW'(1)) * NW'(span + DW'(1)));

    // oldest window row in the ring and left window column
    assign win_slot0 = (out_slot_reg >= SW'(r_eff)) ? SW'(out_slot_reg - SW'(r_eff))
                     : SW'((SW+1)'(out_slot_reg) + (SW+1)'(RING) - (SW+1)'(r_eff));
    assign win_col0  = XW'(out_col_reg - XW'(r_eff));

    assign interior = ((YW+1)'(out_row_reg) >= (YW+1)'(r_eff))
                   && ((HW+1)'(out_row_reg) + (HW+1)'(r_eff) < (HW+1)'(h_eff))
                   && ((XW+1)'(out_col_reg) >= (XW+1)'(r_eff))
                   && ((WW+1)'(out_col_reg) + (WW+1)'(r_eff) < (WW+1)'(w_eff));
    assign out_last = ((HW)'(out_row_reg) == HW'(h_eff - HW'(1)))
                   && ((WW)'(out_col_reg) == WW'(w_eff - WW'(1)));

    // handshakes
    assign pix_in.ready  = (state_reg == ST_IDLE);
    assign pix_out.valid = (state_reg == ST_OUT);
    assign pix_out.red_out       = red_reg;
    assign pix_out.green_out     = green_reg;
    assign pix_out.blue_out      = blue_reg;
    assign pix_out.alpha_out     = alpha_reg;
    assign pix_out.last_of_frame = last_reg;

    assign in_acc    = pix_in.valid && pix_in.ready;
    assign out_acc   = pix_out.valid && pix_out.ready;
    assign pix_acc   = in_acc && (pix_in.op == OP_PIXEL) && !frame_done_reg;
    assign drain_acc = in_acc && (pix_in.op == OP_DRAIN) && frame_done_reg;
    assign cfg_hit   = cfg_we && ((cfg_index == REG_RADIUS) || (cfg_index == REG_FRAME_WIDTH)
                                  || (cfg_index == REG_FRAME_HEIGHT));

    assign in_col_inc  = WW'(in_col_reg) + WW'(1);
    assign in_row_inc  = HW'(in_row_reg) + HW'(1);
    assign out_col_inc = WW'(out_col_reg) + WW'(1);

    // memory addressing: ring slot times row pitch plus column
    assign mem_we  = pix_acc;
    assign wr_addr = AW'(AW'(in_slot_reg) * AW'(MAX_WIDTH)) + AW'(in_col_reg);
    assign rd_addr = (state_reg == ST_SCAN)
                   ? AW'(AW'(AW'(scan_slot_reg) * AW'(MAX_WIDTH)) + AW'(scan_col_reg))
                   : AW'(AW'(AW'(out_slot_reg) * AW'(MAX_WIDTH)) + AW'(out_col_reg));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[wr_addr] <= {pix_in.alpha_in, pix_in.red_in,
                                  pix_in.green_in, pix_in.blue_in};
        end
        rd_data_reg <= line_mem[rd_addr];
    end

    // bit plane compare: upper bits equal to the prefix and current bit clear
    assign hi_mask = 8'hFF << (4'(bit_reg) + 4'd1);

    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            hit[c] = (((rd_data_reg[8*(2-c) +: 8] ^ prefix_reg[c]) & hi_mask) == 8'h00)
                  && !rd_data_reg[8*(2-c) + int'(bit_reg)];
            // rank below the count of zero-bit words: this bit stays zero
            if (rank_reg[c] < cnt_reg[c])
            begin
                prefix_next[c] = prefix_reg[c];
                rank_next[c]   = rank_reg[c];
            end
            else
            begin
                prefix_next[c] = prefix_reg[c] | (8'h01 << bit_reg);
                rank_next[c]   = NW'(rank_reg[c] - cnt_reg[c]);
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (drain_acc)
                    state_next = ST_CTR_RD;
                else if (pix_acc && (in_idx_reg >= lag))
                    state_next = ST_CTR_RD;
            end
            ST_CTR_RD:   state_next = ST_CTR_WAIT;
            ST_CTR_WAIT: state_next = interior ? ST_SCAN : ST_OUT;
            ST_SCAN:
            begin
                if ((dx_reg == span) && (dy_reg == span))
                    state_next = ST_TAIL;
            end
            ST_TAIL:     state_next = ST_DECIDE;
            ST_DECIDE:   state_next = (bit_reg == 3'd0) ? ST_OUT : ST_SCAN;
            ST_OUT:
            begin
                if (out_acc)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // config and frame counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg       <= '0;
            frame_width_reg  <= DIM_CFG_W'(1024);
            frame_height_reg <= DIM_CFG_W'(1024);
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            in_slot_reg      <= '0;
            in_idx_reg       <= '0;
            frame_done_reg   <= 1'b0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            out_slot_reg     <= '0;
        end
        else
        begin
            if (pix_acc)
            begin
                in_idx_reg <= PW'(in_idx_reg + PW'(1));
                if (in_col_inc >= w_eff)
                begin
                    in_col_reg  <= '0;
                    in_slot_reg <= (in_slot_reg == SW'(RING - 1)) ? '0
                                 : SW'(in_slot_reg + SW'(1));
                    if (in_row_inc >= h_eff)
                    begin
                        in_row_reg     <= '0;
                        frame_done_reg <= 1'b1;
                    end
                    else
                    begin
                        in_row_reg <= YW'(in_row_inc);
                    end
                end
                else
                begin
                    in_col_reg <= XW'(in_col_inc);
                end
            end

            if (out_acc)
            begin
                if (last_reg)
                begin
                    // frame finished: start over
                    in_col_reg     <= '0;
                    in_row_reg     <= '0;
                    in_slot_reg    <= '0;
                    in_idx_reg     <= '0;
                    frame_done_reg <= 1'b0;
                    out_col_reg    <= '0;
                    out_row_reg    <= '0;
                    out_slot_reg   <= '0;
                end
                else if (out_col_inc >= w_eff)
                begin
                    out_col_reg  <= '0;
                    out_row_reg  <= YW'(out_row_reg + YW'(1));
                    out_slot_reg <= (out_slot_reg == SW'(RING - 1)) ? '0
                                  : SW'(out_slot_reg + SW'(1));
                end
                else
                begin
                    out_col_reg <= XW'(out_col_inc);
                end
            end

            // a write to a known register index abandons the frame
            if (cfg_hit)
            begin
                unique case (cfg_index)
                    REG_RADIUS:       radius_reg       <= RADIUS_W'(cfg_data);
                    REG_FRAME_WIDTH:  frame_width_reg  <= DIM_CFG_W'(cfg_data);
                    REG_FRAME_HEIGHT: frame_height_reg <= DIM_CFG_W'(cfg_data);
                    default:          radius_reg       <= radius_reg;
                endcase
                in_col_reg     <= '0;
                in_row_reg     <= '0;
                in_slot_reg    <= '0;
                in_idx_reg     <= '0;
                frame_done_reg <= 1'b0;
                out_col_reg    <= '0;
                out_row_reg    <= '0;
                out_slot_reg   <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scan_vld_reg <= 1'b0;
        else
            scan_vld_reg <= (state_reg == ST_SCAN);
    end

    // window walk and radix select datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_CTR_WAIT:
            begin
                // center word: alpha always, colors kept at the border
                alpha_reg     <= rd_data_reg[31:24];
                red_reg       <= rd_data_reg[23:16];
                green_reg     <= rd_data_reg[15:8];
                blue_reg      <= rd_data_reg[7:0];
                last_reg      <= out_last;
                bit_reg       <= 3'd7;
                dx_reg        <= '0;
                dy_reg        <= '0;
                scan_col_reg  <= win_col0;
                scan_slot_reg <= win_slot0;
                for (int c = 0; c < NUM_CHAN; c++)
                begin
                    prefix_reg[c] <= '0;
                    rank_reg[c]   <= NW'(win_size >> 1);
                    cnt_reg[c]    <= '0;
                end
            end
            ST_SCAN, ST_TAIL:
            begin
                if (state_reg == ST_SCAN)
                begin
                    if (dx_reg == span)
                    begin
                        dx_reg        <= '0;
                        dy_reg        <= DW'(dy_reg + DW'(1));
                        scan_col_reg  <= win_col0;
                        scan_slot_reg <= (scan_slot_reg == SW'(RING - 1)) ? '0
                                       : SW'(scan_slot_reg + SW'(1));
                    end
                    else
                    begin
                        dx_reg       <= DW'(dx_reg + DW'(1));
                        scan_col_reg <= XW'(scan_col_reg + XW'(1));
                    end
                end
                if (scan_vld_reg)
                begin
                    for (int c = 0; c < NUM_CHAN; c++)
                    begin
                        if (hit[c])
                            cnt_reg[c] <= NW'(cnt_reg[c] + NW'(1));
                    end
                end
            end
            ST_DECIDE:
            begin
                red_reg       <= prefix_next[0];
                green_reg     <= prefix_next[1];
                blue_reg      <= prefix_next[2];
                bit_reg       <= 3'(bit_reg - 3'd1);
                dx_reg        <= '0;
                dy_reg        <= '0;
                scan_col_reg  <= win_col0;
                scan_slot_reg <= win_slot0;
                for (int c = 0; c < NUM_CHAN; c++)
                begin
                    prefix_reg[c] <= prefix_next[c];
                    rank_reg[c]   <= rank_next[c];
                    cnt_reg[c]    <= '0;
                end
            end
            default:
            begin
                bit_reg <= bit_reg;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/rwmf_checker.sv */
// ----------------------------------------------------------------------------
// rwmf_checker
// port level checks of the rgb window median filter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module rwmf_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] red_out,
    input wire logic       last_of_frame
);

    // stalled output word holds its red channel and last flag
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_out) && $stable(last_of_frame))
        else $error("output word changed while stalled");

    // one word in flight: no input taken while a result waits
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while result pending");

    // after a result is taken the block is back to taking input
    a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> in_ready && !out_valid)
        else $error("block not idle after result taken");

endmodule

bind rgb_window_median_filter rwmf_checker u_rwmf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (pix_in.valid),
    .in_ready      (pix_in.ready),
    .out_valid     (pix_out.valid),
    .out_ready     (pix_out.ready),
    .red_out       (pix_out.red_out),
    .last_of_frame (pix_out.last_of_frame)
);

`default_nettype wire

/* tb/rgb_window_median_filter_tb.sv */
// ----------------------------------------------------------------------------
// rgb_window_median_filter_tb
// self-checking bench for the rgb window median filter: frames of random argb
// pixels, a line-store model that works out window medians in the bench, and
// a scoreboard that compares every output word in order
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_window_median_filter_tb;
    import rwmf_pkg::*;

    localparam int RING_ROWS  = 2 * MAX_RADIUS_DEF + 1;
    // longest internal run of one word (interior pixel at radius five) plus margin
    localparam int SETTLE_CYC = 1100;
    // word budget of the whole run
    localparam int ITEMS_TOTAL = 950;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } filt_px_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rwmf_in_if  in_ch ();
    rwmf_out_if out_ch ();

    rgb_window_median_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (in_ch),
        .pix_out   (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // bench copy of the filter state
    // ------------------------------------------------------------------------
    logic [31:0] line_mem [RING_ROWS][MAX_WIDTH_DEF];
    int unsigned radius_reg;
    int unsigned width_reg;
    int unsigned height_reg;
    int unsigned in_col;
    int unsigned in_row;
    int unsigned out_pos;
    bit          frame_full;

    filt_px_t expected_px [$];

    int errors;
    int words_used;
    int results_seen;
    int frames_sent;
    int burst_left;
    bit no_idle;
    int hold_left;

    // clamp of a frame dimension register
    function automatic int unsigned eff_dim(int unsigned v);
        if (v == 0)
            return 1;
        return (v > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : v;
    endfunction

    function automatic int unsigned eff_radius();
        return (radius_reg > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : radius_reg;
    endfunction

    function automatic void restart_frame();
        in_col     = 0;
        in_row     = 0;
        out_pos    = 0;
        frame_full = 0;
    endfunction

    // median of one channel: the (n/2)-th smallest value of the window
    function automatic logic [7:0] chan_median(int unsigned row, int unsigned col,
                                               int unsigned r, int sh);
        int unsigned hist [256];
        int unsigned want;
        int unsigned acc;
        logic [31:0] w;
        want = ((2 * r + 1) * (2 * r + 1)) / 2;
        acc  = 0;
        foreach (hist[i])
            hist[i] = 0;
        for (int dy = 0; dy <= 2 * r; dy++)
        begin
            for (int dx = 0; dx <= 2 * r; dx++)
            begin
                w = line_mem[(row + dy - r) % RING_ROWS][(col + dx - r) % MAX_WIDTH_DEF];
                hist[(w >> sh) & 8'hff]++;
            end
        end
        for (int v = 0; v < 255; v++)
        begin
            acc += hist[v];
            if (acc > want)
                return v[7:0];
        end
        return 8'hff;
    endfunction

    // next output pixel in raster order goes onto the expected queue
    function automatic void emit_px(int unsigned w, int unsigned h);
        int unsigned r;
        int unsigned row;
        int unsigned col;
        logic [31:0] px;
        filt_px_t e;
        r   = eff_radius();
        row = out_pos / w;
        col = out_pos % w;
        px  = line_mem[row % RING_ROWS][col % MAX_WIDTH_DEF];
        e.red   = px[23:16];
        e.green = px[15:8];
        e.blue  = px[7:0];
        e.alpha = px[31:24];
        e.last  = (out_pos + 1 >= w * h);
        // interior pixels get the window median, the border keeps its colour
        if (row >= r && row + r < h && col >= r && col + r < w)
        begin
            e.red   = chan_median(row, col, r, 16);
            e.green = chan_median(row, col, r, 8);
            e.blue  = chan_median(row, col, r, 0);
        end
        expected_px.push_back(e);
        if (e.last)
            restart_frame();
        else
            out_pos++;
    endfunction

    // one accepted input word; returns 1 when the block acts on it
    function automatic bit predict_word(logic op, logic [7:0] red, logic [7:0] green,
                                        logic [7:0] blue, logic [7:0] alpha);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned idx;
        w = eff_dim(width_reg);
        h = eff_dim(height_reg);
        r = eff_radius();
        if (op == OP_DRAIN)
        begin
            // drain before the frame is complete is dropped
            if (!frame_full)
                return 0;
            emit_px(w, h);
            return 1;
        end
        // pixel after a full frame is dropped until the tail is drained
        if (frame_full)
            return 0;
        idx = in_row * w + in_col;
        line_mem[in_row % RING_ROWS][in_col % MAX_WIDTH_DEF] = {alpha, red, green, blue};
        in_col++;
        if (in_col >= w)
        begin
            in_col = 0;
            in_row++;
            if (in_row >= h)
            begin
                in_row     = 0;
                frame_full = 1;
            end
        end
        if (idx >= r * w + r)
            emit_px(w, h);
        return 1;
    endfunction

    // ------------------------------------------------------------------------
    // clock, reset and timeout
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 0;
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        #100_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // result side: stall pattern, long hold-off and the scoreboard
    // ------------------------------------------------------------------------
    int stall_mode;
    int stall_age;

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            // long hold-off so the block fills up and pushes back
            out_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else
        begin
            // stall pattern, redrawn when stall_age wraps: always ready, half, sparse
            if (stall_age == 0)
                stall_mode = $urandom_range(0, 2);
            stall_age = (stall_age + 1) % 64;
            case (stall_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= $urandom_range(0, 1);
                default: out_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        filt_px_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (expected_px.size() == 0)
            begin
                $error("output word with nothing expected");
                errors++;
            end
            else
            begin
                e = expected_px.pop_front();
                if (out_ch.red_out !== e.red)
                begin
                    $error("red_out expected %0d got %0d", e.red, out_ch.red_out);
                    errors++;
                end
                if (out_ch.green_out !== e.green)
                begin
                    $error("green_out expected %0d got %0d", e.green, out_ch.green_out);
                    errors++;
                end
                if (out_ch.blue_out !== e.blue)
                begin
                    $error("blue_out expected %0d got %0d", e.blue, out_ch.blue_out);
                    errors++;
                end
                if (out_ch.alpha_out !== e.alpha)
                begin
                    $error("alpha_out expected %0d got %0d", e.alpha, out_ch.alpha_out);
                    errors++;
                end
                if (out_ch.last_of_frame !== e.last)
                begin
                    $error("last_of_frame expected %0d got %0d", e.last,
                           out_ch.last_of_frame);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // input side helpers
    // ------------------------------------------------------------------------

    // offer one word, with burst gaps, and log it once accepted
    task automatic send_word(logic op, logic [7:0] red, logic [7:0] green,
                             logic [7:0] blue, logic [7:0] alpha);
        int gap;
        if (burst_left == 0)
        begin
            gap        = no_idle ? 0 : $urandom_range(0, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                @(negedge clk);
                in_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        in_ch.valid    <= 1'b1;
        in_ch.op       <= op;
        in_ch.red_in   <= red;
        in_ch.green_in <= green;
        in_ch.blue_in  <= blue;
        in_ch.alpha_in <= alpha;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (predict_word(op, red, green, blue, alpha))
            words_used++;
        burst_left--;
    endtask

    // random pixel: mostly full range, sometimes clustered or extreme values
    task automatic send_pixel();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 7))
            0: v = {$urandom_range(0, 1) ? 8'hff : 8'h00, 24'(v[0] ? '1 : '0)};
            1: v = v & 32'hff03_0303;
            default: ;
        endcase
        send_word(OP_PIXEL, v[23:16], v[15:8], v[7:0], v[31:24]);
    endtask

    task automatic send_drain();
        send_word(OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // stop offering, let every expected word arrive, then let the block settle
    task automatic wait_idle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (expected_px.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_RADIUS:       radius_reg = val & 3'h7;
            REG_FRAME_WIDTH:  width_reg  = val & 11'h7ff;
            REG_FRAME_HEIGHT: height_reg = val & 11'h7ff;
            default: return;
        endcase
        restart_frame();
    endtask

    task automatic set_frame(int unsigned r, int unsigned w, int unsigned h);
        wait_idle();
        write_reg(REG_RADIUS, r);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    // whole frame: pixels, optional early drains and stray pixels, then the tail
    task automatic send_frame(bit noisy);
        int unsigned n;
        n = eff_dim(width_reg) * eff_dim(height_reg);
        for (int unsigned i = 0; i < n; i++)
        begin
            if (noisy && $urandom_range(0, 15) == 0)
                send_drain();
            send_pixel();
        end
        while (frame_full)
        begin
            if (noisy && $urandom_range(0, 7) == 0)
                send_pixel();
            send_drain();
        end
        frames_sent++;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset values: radius zero over a 1024x1024 frame, every pixel passes through
    task automatic test_reset_defaults();
        send_word(OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(OP_PIXEL, 8'hff, 8'hff, 8'hff, 8'hff);
        send_word(OP_PIXEL, 8'haa, 8'h55, 8'h0f, 8'hf0);
        send_word(OP_PIXEL, 8'h55, 8'haa, 8'hf0, 8'h0f);
        // drain before the frame ends is dropped
        send_drain();
    endtask

    // 3x3 at radius one with extremes, stray pixel and early drain
    task automatic test_directed_small();
        set_frame(1, 3, 3);
        send_word(OP_PIXEL, 8'hff, 8'h00, 8'h80, 8'h01);
        send_drain();
        send_word(OP_PIXEL, 8'h00, 8'hff, 8'h7f, 8'hfe);
        send_word(OP_PIXEL, 8'hff, 8'hff, 8'h00, 8'h00);
        send_word(OP_PIXEL, 8'h00, 8'h00, 8'hff, 8'hff);
        send_word(OP_PIXEL, 8'h12, 8'h34, 8'h56, 8'h78);
        send_word(OP_PIXEL, 8'hff, 8'h00, 8'hff, 8'h00);
        send_word(OP_PIXEL, 8'h00, 8'hff, 8'h00, 8'hff);
        send_word(OP_PIXEL, 8'h80, 8'h80, 8'h80, 8'h80);
        send_word(OP_PIXEL, 8'h01, 8'hfe, 8'h01, 8'hfe);
        // frame complete: a further pixel is dropped
        send_word(OP_PIXEL, 8'hff, 8'hff, 8'hff, 8'hff);
        while (frame_full)
            send_drain();
        // next pixel opens a fresh frame
        send_frame(0);
        // zero sizes act as one: single pixel frame
        set_frame(0, 0, 0);
        send_frame(0);
        // index past the register list changes nothing
        wait_idle();
        write_reg(2'd3, 11'h7ff);
        send_frame(0);
    endtask

    // a register write drops the frame in progress
    task automatic test_abandon();
        set_frame(1, 4, 4);
        repeat (7) send_pixel();
        wait_idle();
        write_reg(REG_RADIUS, 2);
        send_frame(1);
    endtask

    // lag covers all but at most one pixel: outputs come almost all from drains
    task automatic test_small_frame();
        set_frame(2, 3, 2);
        send_frame(0);
        set_frame(3, 2, 5);
        send_frame(1);
    endtask

    // size extremes: clamped widest row and tallest column, started and then
    // dropped by the next register write, and a two-row frame with no interior
    task automatic test_size_extremes();
        set_frame(0, 2047, 1);
        no_idle = 1;
        repeat (24) send_pixel();
        set_frame(0, 1, 2047);
        repeat (24) send_pixel();
        no_idle = 0;
        set_frame(1, 12, 2);
        send_frame(0);
    endtask

    // largest radius, above the clamp too
    task automatic test_max_radius();
        set_frame(5, 11, 11);
        send_frame(0);
        set_frame(7, 12, 12);
        send_frame(1);
    endtask

    // long receiver hold-off while the sender keeps pushing, then a full pause
    task automatic test_backpressure();
        set_frame(1, 8, 6);
        hold_left = 600;
        send_frame(0);
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (expected_px.size() != 0)
            @(posedge clk);
        send_frame(1);
    endtask

    // random frames, mostly small radius, until the word budget is used
    task automatic test_random();
        int unsigned r;
        int unsigned w;
        int unsigned h;
        int target;
        target = ITEMS_TOTAL;
        while (words_used < target)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                r = $urandom_range(4, 7);
                w = $urandom_range(9, 13);
                h = $urandom_range(9, 12);
            end
            else
            begin
                r = $urandom_range(0, 3);
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 10);
            end
            set_frame(r, w, h);
            no_idle = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 2)) send_frame(1);
        end
        no_idle = 0;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_ch.valid    = 1'b0;
        in_ch.op       = OP_PIXEL;
        in_ch.red_in   = '0;
        in_ch.green_in = '0;
        in_ch.blue_in  = '0;
        in_ch.alpha_in = '0;
        out_ch.ready   = 1'b0;
        errors       = 0;
        words_used   = 0;
        results_seen = 0;
        frames_sent  = 0;
        burst_left   = 0;
        no_idle      = 0;
        hold_left    = 0;
        stall_age    = 0;
        stall_mode   = 0;
        radius_reg   = 0;
        width_reg    = MAX_WIDTH_DEF;
        height_reg   = MAX_HEIGHT_DEF;
        restart_frame();
        foreach (line_mem[i, j])
            line_mem[i][j] = '0;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_directed_small();
        test_abandon();
        test_small_frame();
        test_max_radius();
        test_backpressure();
        test_size_extremes();
        test_random();

        // let the tail come out, bounded by the settle time
        wait_idle();

        $display("covered %0d words over %0d frames, %0d output words checked",
                 words_used, frames_sent, results_seen);
        $display("radius 0..7, sizes 0..2047, stray pixels, early drains, hold-offs");
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
hdl/rwmf_pkg.sv
hdl/rwmf_in_if.sv
hdl/rwmf_out_if.sv
hdl/rgb_window_median_filter.sv
hdl/rwmf_checker.sv
tb/rgb_window_median_filter_tb.sv
